// ===== rtl/krwd_pkg.sv =====
// ============================================================================
// krwd_pkg
// Shared types, tables and byte-level functions of the word decryptor.
// ============================================================================
package krwd_pkg;

    localparam int KEY_ENTRIES_DEF = 8192;
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef logic [7:0] byte_t;

    // pipeline control bits between stages
    typedef struct packed {
        logic valid;
        logic dec;
    } stage_ctl_t;

    // key-derived values handed from the key stage to the data stage
    typedef struct packed {
        logic [7:0] t;
        logic       zero;
    } key_info_t;

    // one row: xor mask, then source bit for result bits 7..0
    typedef logic [34:0] perm_row_t;

    function automatic logic [7:0] subst(input logic [7:0] v);
        logic [7:0] r;
        case (v)
            8'h00: r=8'h00; 8'h01: r=8'h1c; 8'h02: r=8'h76; 8'h03: r=8'h6a;
            8'h04: r=8'h5e; 8'h05: r=8'h42; 8'h06: r=8'h24; 8'h07: r=8'h38;
            8'h08: r=8'h4b; 8'h09: r=8'h67; 8'h0a: r=8'had; 8'h0b: r=8'h81;
            8'h0c: r=8'he9; 8'h0d: r=8'hc5; 8'h0e: r=8'h03; 8'h0f: r=8'h2f;
            8'h10: r=8'h45; 8'h11: r=8'h69; 8'h12: r=8'haf; 8'h13: r=8'h83;
            8'h14: r=8'he7; 8'h15: r=8'hcb; 8'h16: r=8'h01; 8'h17: r=8'h2d;
            8'h18: r=8'h02; 8'h19: r=8'h1e; 8'h1a: r=8'h78; 8'h1b: r=8'h64;
            8'h1c: r=8'h5c; 8'h1d: r=8'h40; 8'h1e: r=8'h2a; 8'h1f: r=8'h36;
            8'h20: r=8'h32; 8'h21: r=8'h2e; 8'h22: r=8'h44; 8'h23: r=8'h58;
            8'h24: r=8'he4; 8'h25: r=8'hf8; 8'h26: r=8'h9e; 8'h27: r=8'h82;
            8'h28: r=8'h29; 8'h29: r=8'h05; 8'h2a: r=8'hcf; 8'h2b: r=8'he3;
            8'h2c: r=8'h93; 8'h2d: r=8'hbf; 8'h2e: r=8'h79; 8'h2f: r=8'h55;
            8'h30: r=8'h3f; 8'h31: r=8'h13; 8'h32: r=8'hd5; 8'h33: r=8'hf9;
            8'h34: r=8'h85; 8'h35: r=8'ha9; 8'h36: r=8'h63; 8'h37: r=8'h4f;
            8'h38: r=8'hb8; 8'h39: r=8'ha4; 8'h3a: r=8'hc2; 8'h3b: r=8'hde;
            8'h3c: r=8'h6e; 8'h3d: r=8'h72; 8'h3e: r=8'h18; 8'h3f: r=8'h04;
            8'h40: r=8'h0c; 8'h41: r=8'h10; 8'h42: r=8'h7a; 8'h43: r=8'h66;
            8'h44: r=8'hfc; 8'h45: r=8'he0; 8'h46: r=8'h86; 8'h47: r=8'h9a;
            8'h48: r=8'h47; 8'h49: r=8'h6b; 8'h4a: r=8'ha1; 8'h4b: r=8'h8d;
            8'h4c: r=8'hbb; 8'h4d: r=8'h97; 8'h4e: r=8'h51; 8'h4f: r=8'h7d;
            8'h50: r=8'h17; 8'h51: r=8'h3b; 8'h52: r=8'hfd; 8'h53: r=8'hd1;
            8'h54: r=8'heb; 8'h55: r=8'hc7; 8'h56: r=8'h0d; 8'h57: r=8'h21;
            8'h58: r=8'ha0; 8'h59: r=8'hbc; 8'h5a: r=8'hda; 8'h5b: r=8'hc6;
            8'h5c: r=8'h50; 8'h5d: r=8'h4c; 8'h5e: r=8'h26; 8'h5f: r=8'h3a;
            8'h60: r=8'h3e; 8'h61: r=8'h22; 8'h62: r=8'h48; 8'h63: r=8'h54;
            8'h64: r=8'h46; 8'h65: r=8'h5a; 8'h66: r=8'h3c; 8'h67: r=8'h20;
            8'h68: r=8'h25; 8'h69: r=8'h09; 8'h6a: r=8'hc3; 8'h6b: r=8'hef;
            8'h6c: r=8'hc1; 8'h6d: r=8'hed; 8'h6e: r=8'h2b; 8'h6f: r=8'h07;
            8'h70: r=8'h6d; 8'h71: r=8'h41; 8'h72: r=8'h87; 8'h73: r=8'hab;
            8'h74: r=8'h89; 8'h75: r=8'ha5; 8'h76: r=8'h6f; 8'h77: r=8'h43;
            8'h78: r=8'h1a; 8'h79: r=8'h06; 8'h7a: r=8'h60; 8'h7b: r=8'h7c;
            8'h7c: r=8'h62; 8'h7d: r=8'h7e; 8'h7e: r=8'h14; 8'h7f: r=8'h08;
            8'h80: r=8'h0a; 8'h81: r=8'h16; 8'h82: r=8'h70; 8'h83: r=8'h6c;
            8'h84: r=8'hdc; 8'h85: r=8'hc0; 8'h86: r=8'haa; 8'h87: r=8'hb6;
            8'h88: r=8'h4d; 8'h89: r=8'h61; 8'h8a: r=8'ha7; 8'h8b: r=8'h8b;
            8'h8c: r=8'hf7; 8'h8d: r=8'hdb; 8'h8e: r=8'h11; 8'h8f: r=8'h3d;
            8'h90: r=8'h5b; 8'h91: r=8'h77; 8'h92: r=8'hbd; 8'h93: r=8'h91;
            8'h94: r=8'he1; 8'h95: r=8'hcd; 8'h96: r=8'h0b; 8'h97: r=8'h27;
            8'h98: r=8'h80; 8'h99: r=8'h9c; 8'h9a: r=8'hf6; 8'h9b: r=8'hea;
            8'h9c: r=8'h56; 8'h9d: r=8'h4a; 8'h9e: r=8'h2c; 8'h9f: r=8'h30;
            8'ha0: r=8'hb0; 8'ha1: r=8'hac; 8'ha2: r=8'hca; 8'ha3: r=8'hd6;
            8'ha4: r=8'hee; 8'ha5: r=8'hf2; 8'ha6: r=8'h98; 8'ha7: r=8'h84;
            8'ha8: r=8'h37; 8'ha9: r=8'h1b; 8'haa: r=8'hdd; 8'hab: r=8'hf1;
            8'hac: r=8'h95; 8'had: r=8'hb9; 8'hae: r=8'h73; 8'haf: r=8'h5f;
            8'hb0: r=8'h39; 8'hb1: r=8'h15; 8'hb2: r=8'hdf; 8'hb3: r=8'hf3;
            8'hb4: r=8'h9b; 8'hb5: r=8'hb7; 8'hb6: r=8'h71; 8'hb7: r=8'h5d;
            8'hb8: r=8'hb2; 8'hb9: r=8'hae; 8'hba: r=8'hc4; 8'hbb: r=8'hd8;
            8'hbc: r=8'hec; 8'hbd: r=8'hf0; 8'hbe: r=8'h96; 8'hbf: r=8'h8a;
            8'hc0: r=8'ha8; 8'hc1: r=8'hb4; 8'hc2: r=8'hd2; 8'hc3: r=8'hce;
            8'hc4: r=8'hd0; 8'hc5: r=8'hcc; 8'hc6: r=8'ha6; 8'hc7: r=8'hba;
            8'hc8: r=8'h1f; 8'hc9: r=8'h33; 8'hca: r=8'hf5; 8'hcb: r=8'hd9;
            8'hcc: r=8'hfb; 8'hcd: r=8'hd7; 8'hce: r=8'h1d; 8'hcf: r=8'h31;
            8'hd0: r=8'h57; 8'hd1: r=8'h7b; 8'hd2: r=8'hb1; 8'hd3: r=8'h9d;
            8'hd4: r=8'hb3; 8'hd5: r=8'h9f; 8'hd6: r=8'h59; 8'hd7: r=8'h75;
            8'hd8: r=8'h8c; 8'hd9: r=8'h90; 8'hda: r=8'hfa; 8'hdb: r=8'he6;
            8'hdc: r=8'hf4; 8'hdd: r=8'he8; 8'hde: r=8'h8e; 8'hdf: r=8'h92;
            8'he0: r=8'h12; 8'he1: r=8'h0e; 8'he2: r=8'h68; 8'he3: r=8'h74;
            8'he4: r=8'he2; 8'he5: r=8'hfe; 8'he6: r=8'h94; 8'he7: r=8'h88;
            8'he8: r=8'h65; 8'he9: r=8'h49; 8'hea: r=8'h8f; 8'heb: r=8'ha3;
            8'hec: r=8'h99; 8'hed: r=8'hb5; 8'hee: r=8'h7f; 8'hef: r=8'h53;
            8'hf0: r=8'h35; 8'hf1: r=8'h19; 8'hf2: r=8'hd3; 8'hf3: r=8'hff;
            8'hf4: r=8'hc9; 8'hf5: r=8'he5; 8'hf6: r=8'h23; 8'hf7: r=8'h0f;
            8'hf8: r=8'hbe; 8'hf9: r=8'ha2; 8'hfa: r=8'hc8; 8'hfb: r=8'hd4;
            8'hfc: r=8'h4e; 8'hfd: r=8'h52; 8'hfe: r=8'h34; 8'hff: r=8'h28;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    // pack a row: mask, then sources for bits 7..0
    function automatic perm_row_t mk(input logic [7:0] m,
        input int a, input int b, input int c,
        input int d, input int e, input int f,
        input int g, input int h);
        return {m, 3'(a), 3'(b), 3'(c), 3'(d), 3'(e), 3'(f), 3'(g), 3'(h), 3'd0};
    endfunction

    function automatic perm_row_t pre_row(input logic [3:0] i);
        perm_row_t r;
        case (i)
            4'd0:  r = mk(8'h23,6,4,5,7,3,0,1,2);
            4'd1:  r = mk(8'h92,2,5,3,6,7,1,0,4);
            4'd2:  r = mk(8'hb8,6,7,4,2,0,5,1,3);
            4'd3:  r = mk(8'h74,5,3,7,1,4,6,0,2);
            4'd4:  r = mk(8'hcf,7,4,1,0,6,2,3,5);
            4'd5:  r = mk(8'hc4,3,1,6,4,5,0,2,7);
            4'd6:  r = mk(8'h51,5,7,2,4,3,1,6,0);
            4'd7:  r = mk(8'h14,7,2,0,6,1,3,4,5);
            4'd8:  r = mk(8'h7f,3,5,6,0,2,1,7,4);
            4'd9:  r = mk(8'h03,2,3,4,0,6,7,5,1);
            4'd10: r = mk(8'h96,3,1,7,5,2,4,6,0);
            4'd11: r = mk(8'h30,7,6,2,3,0,4,5,1);
            4'd12: r = mk(8'he2,1,0,3,7,4,5,2,6);
            4'd13: r = mk(8'h72,1,6,0,5,7,2,4,3);
            4'd14: r = mk(8'hf5,0,4,1,2,6,5,7,3);
            default: r = mk(8'h5b,0,7,5,3,1,4,2,6);
        endcase
        return r;
    endfunction

    function automatic perm_row_t post_row(input logic [3:0] i);
        perm_row_t r;
        case (i)
            4'd0:  r = mk(8'h55,6,5,1,0,7,4,2,3);
            4'd1:  r = mk(8'h94,7,6,4,2,0,5,1,3);
            4'd2:  r = mk(8'h8d,1,4,2,3,0,6,7,5);
            4'd3:  r = mk(8'h9a,4,3,5,6,0,2,1,7);
            4'd4:  r = mk(8'h72,4,3,7,0,5,6,1,2);
            4'd5:  r = mk(8'hff,1,7,2,3,6,4,5,0);
            4'd6:  r = mk(8'h06,6,5,3,2,4,1,0,7);
            4'd7:  r = mk(8'hc5,3,5,1,4,2,7,0,6);
            4'd8:  r = mk(8'hec,4,7,5,1,6,0,2,3);
            4'd9:  r = mk(8'h89,3,5,0,6,1,2,7,4);
            4'd10: r = mk(8'h5c,1,3,0,7,5,2,4,6);
            4'd11: r = mk(8'h3f,7,3,0,2,4,6,1,5);
            4'd12: r = mk(8'h57,6,4,7,2,1,5,3,0);
            4'd13: r = mk(8'hf7,6,3,7,0,5,4,2,1);
            4'd14: r = mk(8'h3a,6,1,3,2,7,4,5,0);
            default: r = mk(8'hac,1,6,3,5,0,7,4,2);
        endcase
        return r;
    endfunction

    // apply the source list of a row: result bit 7-i takes source i
    function automatic logic [7:0] perm_apply(input logic [7:0] v, input perm_row_t p);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[7-i] = v[p[26-3*i -: 3]];
        return r;
    endfunction

    function automatic logic [7:0] pl(input logic [7:0] v,
        input int a, input int b, input int c,
        input int d, input int e, input int f,
        input int g, input int h);
        return perm_apply(v, mk(8'h00, a, b, c, d, e, f, g, h));
    endfunction

    // rearrange a key byte; op selects the opcode form
    function automatic logic [7:0] shuffle_key(input logic [7:0] k, input logic op);
        logic [7:0] t;
        t = k;
        if (!op) begin
            t = t ^ 8'h30;
            if (!t[3]) t = t ^ 8'h02;
            t = pl(t,1,0,6,4,3,5,2,7);
            if (t[6]) t = pl(t,7,6,2,4,5,3,1,0);
        end
        else begin
            t = t ^ 8'h1c;
            if (!t[3]) t = t ^ 8'h20;
            if (t[7]) t = t ^ 8'h40;
            t = pl(t,5,7,6,4,2,3,1,0);
            if (t[6]) t = pl(t,7,6,5,3,2,4,1,0);
        end
        if (t[6]) begin
            if (t[5]) t = t ^ 8'h10;
        end
        else if (!t[4]) begin
            t = t ^ 8'h20;
        end
        return t;
    endfunction

    function automatic logic sel_bit(input logic [7:0] t, input logic op);
        if (!op)
            return (!t[6] && t[2]) ^ t[4];
        return (t[6] && t[2]) ^ t[5];
    endfunction

    // permutation, xor stages and substitution
    function automatic logic [7:0] front(input logic [7:0] v, input logic [7:0] t,
                                        input logic op);
        logic [7:0] r;
        perm_row_t  p;
        p = pre_row(t[7:4]);
        r = perm_apply(v, p) ^ p[34:27];
        if (t[3]) r = r ^ 8'h01;
        if (t[0]) r = r ^ 8'hb1;
        if (op) r = r ^ 8'h34;
        if (!op && t[6]) r = r ^ 8'h01;
        return subst(r);
    endfunction

    // variant A or B final stage
    function automatic logic [7:0] back(input logic [7:0] vin, input logic [7:0] t,
                                       input logic op, input logic var_b);
        logic [7:0] v;
        logic       x;
        perm_row_t  q;
        v = vin;
        x = sel_bit(t, op);
        if (!var_b) begin
            if (t[0]) begin
                if (v[0]) v = v ^ 8'hc0;
                if (!v[6] ^ v[4]) v = pl(v,7,6,5,4,1,0,2,3);
            end
            else if (!v[6] ^ v[4]) begin
                v = pl(v,7,6,5,4,0,1,3,2);
            end
            if (!v[6]) v = pl(v,7,6,5,4,2,3,0,1);
            q = post_row({x, t[2:0]});
            v = v ^ q[34:27];
            return perm_apply(v, q);
        end
        v[0] = v[0] ^ x;
        if (t[2]) begin
            v = pl(v,7,6,5,4,1,0,3,2);
            if (t[0] ^ t[1]) v = pl(v,7,6,5,4,0,1,3,2);
        end
        else begin
            v = pl(v,7,6,5,4,3,2,0,1);
            if (t[0] ^ t[1]) v = pl(v,7,6,5,4,1,0,2,3);
        end
        return v;
    endfunction

endpackage

// ===== rtl/krwd_key_store.sv =====
// ============================================================================
// krwd_key_store
// Key memory: one write port for loads, two registered read ports that
// fetch the opcode and data keys of one word.
// ============================================================================
module krwd_key_store #(
    parameter int KEY_ENTRIES = krwd_pkg::KEY_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(KEY_ENTRIES)-1:0] waddr,
    input  krwd_pkg::byte_t                wdata,
    input  logic                           re,
    input  logic [$clog2(KEY_ENTRIES)-2:0] row,
    output krwd_pkg::byte_t                op_key,
    output krwd_pkg::byte_t                dt_key
);
    import krwd_pkg::*;

    localparam int AW = $clog2(KEY_ENTRIES);

    byte_t mem [KEY_ENTRIES];

    // write a key byte on a load transfer
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read both halves at one row
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            op_key <= mem[{1'b0, row}];
            dt_key <= mem[{1'b1, row[AW-2:0]}];
        end
    end

endmodule

// ===== rtl/krwd_lane.sv =====
// ============================================================================
// krwd_lane
// Byte decryption for one key half: key shuffle, front and back stages,
// each ending in a register under the shared advance enable.
// ============================================================================
module krwd_lane #(
    parameter logic OP = 1'b1
) (
    input  logic            clk,
    input  logic            adv,
    input  logic            var_b,
    input  krwd_pkg::byte_t key,
    input  krwd_pkg::byte_t cbyte,
    output krwd_pkg::byte_t pbyte
);
    import krwd_pkg::*;

    key_info_t ki_reg, ki2_reg;
    byte_t     cb_reg, v_reg, cb2_reg, pb_reg;

    // shuffle the key
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ki_reg.t    <= shuffle_key(key, OP);
            ki_reg.zero <= (key == 8'h00);
            cb_reg      <= cbyte;
        end
    end

    // front stage through substitution
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg   <= front(cb_reg, ki_reg.t, OP);
            ki2_reg <= ki_reg;
            cb2_reg <= cb_reg;
        end
    end

    // final stage, or pass through on a zero key
    always_ff @(posedge clk)
    begin
        if (adv)
            pb_reg <= ki2_reg.zero ? cb2_reg : back(v_reg, ki2_reg.t, OP, var_b);
    end

    assign pbyte = pb_reg;

endmodule

// ===== rtl/keyed_rom_word_decryptor.sv =====
// ============================================================================
// keyed_rom_word_decryptor
// Decrypts 16-bit program words with a loaded key store, opcode and data.
// ============================================================================
// Usage:
//   Input channel in_valid/in_stall carries func, key_index, key_byte,
//   byte_addr and cipher_word. func 0 writes key_byte at key_index; func 1
//   decrypts cipher_word at byte_addr. Every item yields one result on
//   out_valid/out_stall: opcode_word and data_word (both zero for a load).
//   Load every key entry a word will use before decrypting with it.
//   cfg_valid/cfg_ready writes variant (0: variant A, 1: variant B);
//   write it only while the pipeline is empty.
//   The result passes five registers in turn (key memory read, key shuffle,
//   front stage, final stage, output register).
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the five-stage pipeline with a dual-read key memory.
//   Reset clears all valid bits and variant; the key memory is not cleared.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises; nothing is lost or repeated.
// ============================================================================
module keyed_rom_word_decryptor #(
    parameter int KEY_ENTRIES = krwd_pkg::KEY_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [$clog2(KEY_ENTRIES)-1:0] key_index,
    input  logic [7:0]                     key_byte,
    input  logic [23:0]                    byte_addr,
    input  logic [15:0]                    cipher_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [15:0]                    opcode_word,
    output logic [15:0]                    data_word,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);
    import krwd_pkg::*;

    localparam int AW    = $clog2(KEY_ENTRIES);
    localparam int DEPTH = 5;

    stage_ctl_t ctl_reg [DEPTH];
    logic       variant_reg;
    logic       adv;
    logic       in_xfer;
    logic [AW-2:0] row;
    logic [15:0] w1_reg, w2_reg, w3_reg, w4_reg, op_out_reg, dt_out_reg;
    byte_t op_key, dt_key, op_pb, dt_pb;
    byte_t cbyte;

    // whole pipeline moves unless the output holds a stalled result
    assign adv      = !(ctl_reg[DEPTH-1].valid && out_stall);
    assign in_stall = !adv;
    assign in_xfer  = in_valid && adv;
    assign cfg_ready = 1'b1;

    // key row from address bits 1, 3, 5, 9 and 23..16
    assign row = (AW-1)'({byte_addr[23:16], byte_addr[9], byte_addr[5],
                          byte_addr[3], byte_addr[1]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            variant_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            variant_reg <= cfg_data;
    end

    // advance valid and kind bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                ctl_reg[i] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= '{valid: in_valid, dec: func == FUNC_DECRYPT};
            for (int i = 1; i < DEPTH; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    krwd_key_store #(.KEY_ENTRIES(KEY_ENTRIES)) u_keys (
        .clk    (clk),
        .we     (in_xfer && func == FUNC_LOAD),
        .waddr  (key_index),
        .wdata  (key_byte),
        .re     (adv),
        .row    (row),
        .op_key (op_key),
        .dt_key (dt_key)
    );

    // carry the word alongside the byte lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg <= cipher_word;
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
            w4_reg <= w3_reg;
        end
    end

    assign cbyte = {w1_reg[15:10], w1_reg[6], w1_reg[3]};

    krwd_lane #(.OP(1'b1)) u_op (
        .clk(clk), .adv(adv), .var_b(variant_reg),
        .key(op_key), .cbyte(cbyte), .pbyte(op_pb)
    );

    krwd_lane #(.OP(1'b0)) u_dt (
        .clk(clk), .adv(adv), .var_b(variant_reg),
        .key(dt_key), .cbyte(cbyte), .pbyte(dt_pb)
    );

    // merge the byte back into the word; zero for loads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_out_reg <= ctl_reg[DEPTH-2].dec ?
                {op_pb[7:2], w4_reg[9:7], op_pb[1], w4_reg[5:4], op_pb[0], w4_reg[2:0]}
                : 16'h0000;
            dt_out_reg <= ctl_reg[DEPTH-2].dec ?
                {dt_pb[7:2], w4_reg[9:7], dt_pb[1], w4_reg[5:4], dt_pb[0], w4_reg[2:0]}
                : 16'h0000;
        end
    end

    assign out_valid   = ctl_reg[DEPTH-1].valid;
    assign opcode_word = op_out_reg;
    assign data_word   = dt_out_reg;

endmodule

// ===== rtl/krwd_checker.sv =====
// ============================================================================
// krwd_checker
// Port-level checks of the word decryptor, bound to the top level.
// ============================================================================
module krwd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        func,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] opcode_word,
    input logic [15:0] data_word
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(opcode_word) && $stable(data_word))
        else $error("stalled result changed");

    // back pressure only from a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // a load yields zero words once it has passed the pipeline with no stall
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !func ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid && opcode_word == 16'h0000 && data_word == 16'h0000)
        else $error("load result not zero");

    // a free pipeline keeps its items flowing
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("item lost in pipeline");
endmodule

bind keyed_rom_word_decryptor krwd_checker u_krwd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .out_valid(out_valid), .out_stall(out_stall),
    .opcode_word(opcode_word), .data_word(data_word)
);
